// File: hw/rtl/sffl_pkg.sv
// ----------------------------------------------------------------------------
// sffl_pkg
// Shared types and constants for the stereo feedback flanger: sequencer
// states, register indexes, fixed-point gains and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package sffl_pkg;

  // Default sizes handed to the top level
  localparam int unsigned LineDepthDef  = 512;
  localparam int unsigned SampleBitsDef = 24;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned PhaseW   = 32;
  localparam int unsigned MaxDlyW  = 9;
  localparam int unsigned MixW     = 17;

  localparam logic [CfgIdxW-1:0] CFG_PHASE_INC = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_DELAY = 2'd1;

  localparam logic [PhaseW-1:0]  PHASE_INC_RST = 32'd17896;
  localparam logic [MaxDlyW-1:0] MAX_DELAY_RST = 9'd384;

  // Q0.16 gains and Q1.16 mix limits
  localparam logic [16:0] MIX_ONE    = 17'd65536;
  localparam logic [16:0] BYPASS_MIX = 17'd65;
  localparam logic [15:0] GAIN_0P7   = 16'd45875;
  localparam logic [15:0] GAIN_0P5   = 16'd32768;
  localparam logic [15:0] GAIN_0P3   = 16'd19661;

  // Shared multiplier operand B width (signed)
  localparam int unsigned MulBW = 18;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DELAY,
    ST_ADDR,
    ST_RD_A,
    ST_RD_B,
    ST_RD_W,
    ST_MUL_A,
    ST_MUL_B,
    ST_WET,
    ST_GAIN,
    ST_MIX,
    ST_FBK,
    ST_WB,
    ST_WRITE,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// File: hw/rtl/stereo_feedback_flanger_unit.sv
// ----------------------------------------------------------------------------
// stereo_feedback_flanger_unit
// Stereo feedback flanger: triangle LFO, linearly interpolated delay read,
// feedback write-back and wet/dry output, all on one shared multiplier.
// ----------------------------------------------------------------------------
// After reset the unit sweeps both delay lines to zero, one entry a cycle;
// input beats are refused meanwhile, configuration writes are taken at any
// time. A processed stereo pair is paced by the single 33x18 multiplier,
// which steps through twelve products per pair, and by the delay memory,
// read twice per pair; the next pair is taken only once the last one has
// gone to the result register. A bypassed pair (mix of 65 or less) goes
// from acceptance straight to the last step and on to the result register,
// and the delay lines, write pointer and LFO phase are left unchanged.
// The result register lets the next beat be accepted while a result waits;
// a second finished pair holds the sequencer in its last step until the
// waiting result is taken.
`default_nettype none

module stereo_feedback_flanger_unit
  import sffl_pkg::*;
#(
  parameter int unsigned LINE_DEPTH  = LineDepthDef,
  parameter int unsigned SAMPLE_BITS = SampleBitsDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration writes
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [CfgDataW-1:0]    cfg_data_i,
  // input beats
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0] left_in_i,
  input  wire logic [SAMPLE_BITS-1:0] right_in_i,
  input  wire logic [MixW-1:0]        mix_amount_i,
  // result beats
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0]      left_out_o,
  output logic [SAMPLE_BITS-1:0]      right_out_o
);

  localparam int unsigned S     = SAMPLE_BITS;
  localparam int unsigned PW    = $clog2(LINE_DEPTH);
  localparam int unsigned IW    = PW + 2;
  localparam int unsigned DlyW  = PW + 16;
  localparam int unsigned MaW   = (SAMPLE_BITS + 1 > 33) ? SAMPLE_BITS + 1 : 33;
  localparam int unsigned ProdW = MaW + MulBW;
  localparam int unsigned WordW = 2 * SAMPLE_BITS;
  localparam int unsigned MdMax = LINE_DEPTH - 3;

  // Saturate an (S+1)-bit signed sum to S bits
  function automatic logic [S-1:0] sat_s(input logic [S:0] v);
    logic [S-1:0] r;
    if (v[S] != v[S-1]) begin
      r = v[S] ? {1'b1, {(S-1){1'b0}}} : {1'b0, {(S-1){1'b1}}};
    end else begin
      r = v[S-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [MaW-1:0] sext_a(input logic [S-1:0] v);
    return $signed({{(MaW-S){v[S-1]}}, v});
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e state_q, state_d;

  logic [PhaseW-1:0]  phase_inc_q;
  logic [MaxDlyW-1:0] max_dly_q;
  logic [PhaseW-1:0]  phase_q;
  logic [PW-1:0]      wp_q;
  logic [PW-1:0]      clr_cnt_q;
  logic               ch_q;
  logic               byp_q;
  logic               out_valid_q;

  logic [S-1:0]       dl_q, dr_q;
  logic [MixW-1:0]    mix_q;
  logic [PW-1:0]      idx_q, nxt_q;
  logic [15:0]        f_q;
  logic [16:0]        wf_q;
  logic [15:0]        fb_q;
  logic [S-1:0]       al_q, ar_q, bl_q, br_q;
  logic signed [ProdW-1:0] prod_q, acc_q;
  logic [S-1:0]       wet_q;
  logic [S-1:0]       ol_q, or_q;
  logic [S-1:0]       wbl_q, wbr_q;
  logic [S-1:0]       lout_q, rout_q;
  logic [WordW-1:0]   rd_q;

  // Delay memory: left sample in the upper half, right in the lower
  logic [WordW-1:0]   line_mem [LINE_DEPTH];

  // --------------------------------------------------------------------------
  // Combinational helpers
  // --------------------------------------------------------------------------
  logic                    in_acc, out_load;
  logic [PW-1:0]           md_eff;
  logic [PhaseW-1:0]       lfo32;
  logic                    lfo_full;
  logic [DlyW-1:0]         delay;
  logic [IW-1:0]           base, base_w;
  logic [PW-1:0]           idx_c, nxt_c;
  logic [MixW-1:0]         mix_clamp;
  logic [S-1:0]            a_sel, b_sel, dry_sel;
  logic signed [ProdW-1:0] sum_ab;
  logic [S-1:0]            prod_sh, sum_sh;
  logic [S:0]              out_sum, wb_sum;

  logic signed [MaW-1:0]   mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] mul_p;

  logic                    mem_we;
  logic [PW-1:0]           mem_waddr, mem_raddr;
  logic [WordW-1:0]        mem_wdata;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // Peak delay limited to the line length minus three
  assign md_eff = (32'(max_dly_q) > MdMax) ? PW'(MdMax) : PW'(max_dly_q);

  // Triangle LFO |2*phase - 1| in Q0.32; full scale only at phase zero
  assign lfo32    = phase_q[PhaseW-1] ? {phase_q[PhaseW-2:0], 1'b0}
                                      : (PhaseW'(0) - {phase_q[PhaseW-2:0], 1'b0});
  assign lfo_full = (phase_q == '0);

  // Fractional delay, 16 fraction bits
  assign delay = lfo_full ? {md_eff, 16'h0000} : prod_q[16 +: DlyW];

  // Read position wp - delay - 1, integer part floored, wrapped once
  assign base   = IW'(wp_q) + IW'(LINE_DEPTH - 1) - IW'(delay[DlyW-1:16])
                - IW'(delay[15:0] != 16'h0000);
  assign base_w = (base >= IW'(LINE_DEPTH)) ? base - IW'(LINE_DEPTH) : base;
  assign idx_c  = base_w[PW-1:0];
  assign nxt_c  = (idx_c == PW'(LINE_DEPTH - 1)) ? '0 : idx_c + PW'(1);

  assign mix_clamp = (mix_amount_i > MIX_ONE) ? MIX_ONE : mix_amount_i;

  // Per-channel operand selection
  assign a_sel   = ch_q ? ar_q : al_q;
  assign b_sel   = ch_q ? br_q : bl_q;
  assign dry_sel = ch_q ? dr_q : dl_q;

  // Floored >> 16 views of the product and the interpolation sum
  assign sum_ab  = acc_q + prod_q;
  assign prod_sh = prod_q[16 +: S];
  assign sum_sh  = sum_ab[16 +: S];
  assign out_sum = {dry_sel[S-1], dry_sel} - {prod_sh[S-1], prod_sh};
  assign wb_sum  = {dry_sel[S-1], dry_sel} + {prod_sh[S-1], prod_sh};

  // Shared multiplier
  assign mul_p = ProdW'(mul_a * mul_b);

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == PW'(LINE_DEPTH - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (mix_amount_i <= BYPASS_MIX) ? ST_DONE : ST_DELAY;
        end
      end
      ST_DELAY: state_d = ST_ADDR;
      ST_ADDR:  state_d = ST_RD_A;
      ST_RD_A:  state_d = ST_RD_B;
      ST_RD_B:  state_d = ST_RD_W;
      ST_RD_W:  state_d = ST_MUL_A;
      ST_MUL_A: state_d = ST_MUL_B;
      ST_MUL_B: state_d = ST_WET;
      ST_WET:   state_d = ST_GAIN;
      ST_GAIN:  state_d = ST_MIX;
      ST_MIX:   state_d = ST_FBK;
      ST_FBK:   state_d = ST_WB;
      ST_WB:    state_d = ch_q ? ST_WRITE : ST_MUL_A;
      ST_WRITE: state_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: multiplier operands, memory control, handshakes
  // --------------------------------------------------------------------------
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    mem_we     = 1'b0;
    mem_waddr  = wp_q;
    mem_wdata  = {wbl_q, wbr_q};
    mem_raddr  = idx_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
      end
      ST_IDLE:  in_ready_o = 1'b1;
      ST_DELAY: begin
        mul_a = $signed({{(MaW-PhaseW){1'b0}}, lfo32});
        mul_b = $signed({{(MulBW-PW){1'b0}}, md_eff});
      end
      ST_ADDR: begin
        mul_a = $signed({{(MaW-MixW){1'b0}}, mix_q});
        mul_b = $signed({2'b00, GAIN_0P3});
      end
      ST_RD_A:  mem_raddr = idx_q;
      ST_RD_B:  mem_raddr = nxt_q;
      ST_MUL_A: begin
        mul_a = sext_a(a_sel);
        mul_b = $signed({1'b0, wf_q});
      end
      ST_MUL_B: begin
        mul_a = sext_a(b_sel);
        mul_b = $signed({2'b00, f_q});
      end
      ST_GAIN: begin
        mul_a = sext_a(wet_q);
        mul_b = $signed({2'b00, GAIN_0P7});
      end
      ST_MIX: begin
        mul_a = sext_a(prod_sh);
        mul_b = $signed({1'b0, mix_q});
      end
      ST_FBK: begin
        mul_a = sext_a(wet_q);
        mul_b = $signed({2'b00, fb_q});
      end
      ST_WRITE: mem_we = 1'b1;
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      phase_inc_q <= PHASE_INC_RST;
      max_dly_q   <= MAX_DELAY_RST;
      phase_q     <= '0;
      wp_q        <= '0;
      ch_q        <= 1'b0;
      byp_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + PW'(1);

      // configuration beat
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_PHASE_INC: phase_inc_q <= cfg_data_i;
          CFG_MAX_DELAY: max_dly_q   <= cfg_data_i[MaxDlyW-1:0];
          default: begin
          end
        endcase
      end

      if (in_acc) byp_q <= (mix_amount_i <= BYPASS_MIX);

      // channel select for the per-channel steps
      if (state_q == ST_RD_W) ch_q <= 1'b0;
      else if (state_q == ST_WB) ch_q <= ~ch_q;

      // pointer and phase advance once per processed pair
      if (state_q == ST_WRITE) begin
        wp_q    <= (wp_q == PW'(LINE_DEPTH - 1)) ? '0 : wp_q + PW'(1);
        phase_q <= phase_q + phase_inc_q;
      end

      // result register handshake
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;

    if (in_acc) begin
      dl_q  <= left_in_i;
      dr_q  <= right_in_i;
      mix_q <= mix_clamp;
    end

    // read position and interpolation weights
    if (state_q == ST_ADDR) begin
      idx_q <= idx_c;
      nxt_q <= nxt_c;
      f_q   <= 16'h0000 - delay[15:0];
      wf_q  <= MIX_ONE - {1'b0, 16'h0000 - delay[15:0]};
    end

    // feedback gain 0.5 + 0.3 * mix
    if (state_q == ST_RD_A) fb_q <= GAIN_0P5 + prod_q[16 +: 16];

    if (state_q == ST_RD_B) begin
      al_q <= rd_q[WordW-1:S];
      ar_q <= rd_q[S-1:0];
    end
    if (state_q == ST_RD_W) begin
      bl_q <= rd_q[WordW-1:S];
      br_q <= rd_q[S-1:0];
    end

    if (state_q == ST_MUL_B) acc_q <= prod_q;
    if (state_q == ST_WET) wet_q <= sum_sh;

    if (state_q == ST_FBK) begin
      if (ch_q) or_q <= sat_s(out_sum);
      else      ol_q <= sat_s(out_sum);
    end
    if (state_q == ST_WB) begin
      if (ch_q) wbr_q <= sat_s(wb_sum);
      else      wbl_q <= sat_s(wb_sum);
    end

    if (out_load) begin
      lout_q <= byp_q ? dl_q : ol_q;
      rout_q <= byp_q ? dr_q : or_q;
    end
  end

  // --------------------------------------------------------------------------
  // Delay memory, one write and one registered read per cycle
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) line_mem[mem_waddr] <= mem_wdata;
    rd_q <= line_mem[mem_raddr];
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign left_out_o  = lout_q;
  assign right_out_o = rout_q;

endmodule

`default_nettype wire

// File: test/stereo_feedback_flanger_unit_tb.sv
// ----------------------------------------------------------------------------
// stereo_feedback_flanger_unit_tb
// Self-checking bench for the stereo flanger. Stereo pairs go in over a
// valid/ready channel with random gaps, results come back under random
// back-pressure, and each result beat is compared with a bit-exact predictor
// of the LFO, interpolated delay read, wet/dry mix and feedback write-back.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_feedback_flanger_unit_tb
  import sffl_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SW          = SampleBitsDef;
  localparam int unsigned DEPTH       = LineDepthDef;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 30;
  localparam int unsigned SWEEP_ITEMS = 260;

  // register indexes with no register behind them
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 2'd3;

  localparam logic [SW-1:0]   PEAK_POS     = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0]   PEAK_NEG     = {1'b1, {(SW-1){1'b0}}};
  localparam logic [MixW-1:0] MIX_ALL_ONES = '1;

  // signed copies of the Q0.16 gains and the Q1.16 unity mix, with turn and sample bounds, for the predictor
  localparam longint UNITY      = longint'(MIX_ONE);
  localparam longint WET_GAIN   = longint'(GAIN_0P7);
  localparam longint FBK_BASE   = longint'(GAIN_0P5);
  localparam longint FBK_SLOPE  = longint'(GAIN_0P3);
  localparam longint HALF_TURN  = longint'(1) <<< 31;
  localparam longint FULL_TURN  = longint'(1) <<< 32;
  localparam longint SAMPLE_MAX = (longint'(1) <<< (SW - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  typedef struct packed {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
  } stereo_pair_t;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_valid_i  = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i  = '0;
  logic [CfgDataW-1:0]  cfg_data_i   = '0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_ready_o;
  logic [SW-1:0]        left_in_i    = '0;
  logic [SW-1:0]        right_in_i   = '0;
  logic [MixW-1:0]      mix_amount_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i  = 1'b0;
  logic [SW-1:0]        left_out_o;
  logic [SW-1:0]        right_out_o;

  // predictor state and register copies
  longint               echo_left  [DEPTH];
  longint               echo_right [DEPTH];
  int unsigned          line_ptr;
  logic [PhaseW-1:0]    sweep_phase;
  logic [PhaseW-1:0]    cfg_phase_step;
  logic [MaxDlyW-1:0]   cfg_peak_delay;

  stereo_pair_t         pending_pairs[$];
  int unsigned          error_count      = 0;
  int unsigned          idle_cycles      = 0;
  bit                   sender_idle_on   = 1'b1;
  bit                   receiver_idle_on = 1'b1;
  bit                   hold_request     = 1'b0;

  stereo_feedback_flanger_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .left_in_i    (left_in_i),
    .right_in_i   (right_in_i),
    .mix_amount_i (mix_amount_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .left_out_o   (left_out_o),
    .right_out_o  (right_out_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint clamp_sample(longint v);
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    if (v < SAMPLE_MIN) return SAMPLE_MIN;
    return v;
  endfunction

  // One pair; a processed pair advances the delay lines, pointer and LFO phase
  function automatic stereo_pair_t flanger_predict(logic signed [SW-1:0] dry_l,
                                                   logic signed [SW-1:0] dry_r,
                                                   logic [MixW-1:0]      mix_raw);
    stereo_pair_t res;
    longint dl, dr, mix, lfo, peak, dly, rp, idx, nxt, frac, wl, wr, fb, ol, orr;
    dl = dry_l;
    dr = dry_r;
    // bypass: pair passes through, nothing moves
    if (mix_raw <= BYPASS_MIX) begin
      res.left  = dry_l;
      res.right = dry_r;
      return res;
    end
    mix = (mix_raw > MIX_ONE) ? UNITY : longint'(mix_raw);

    // triangle LFO in Q0.32
    lfo = longint'({32'd0, sweep_phase});
    if (sweep_phase[PhaseW-1]) lfo = (lfo - HALF_TURN) * 2;
    else                       lfo = FULL_TURN - lfo * 2;

    peak = longint'({23'd0, cfg_peak_delay});
    if (peak > DEPTH - 3) peak = DEPTH - 3;
    dly = (lfo * peak) >>> 16;

    // read position one sample behind the delay, Q.16
    rp   = ((longint'(line_ptr) + DEPTH) <<< 16) - dly - UNITY;
    idx  = (rp >>> 16) % DEPTH;
    nxt  = (idx + 1) % DEPTH;
    frac = rp & 64'hFFFF;

    wl = (echo_left[idx] * (UNITY - frac) + echo_left[nxt] * frac) >>> 16;
    wr = (echo_right[idx] * (UNITY - frac) + echo_right[nxt] * frac) >>> 16;

    ol  = clamp_sample(dl - ((((wl * WET_GAIN) >>> 16) * mix) >>> 16));
    orr = clamp_sample(dr - ((((wr * WET_GAIN) >>> 16) * mix) >>> 16));

    // feedback write-back
    fb = FBK_BASE + ((mix * FBK_SLOPE) >>> 16);
    echo_left[line_ptr]  = clamp_sample(dl + ((wl * fb) >>> 16));
    echo_right[line_ptr] = clamp_sample(dr + ((wr * fb) >>> 16));

    line_ptr    = (line_ptr + 1) % DEPTH;
    sweep_phase = sweep_phase + cfg_phase_step;

    res.left  = ol[SW-1:0];
    res.right = orr[SW-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Random field values
  // ---------------------------------------------------------------------------
  function automatic logic [SW-1:0] random_sample();
    logic [31:0] raw;
    case ($urandom_range(0, 9))
      0:       raw = 32'($urandom_range(0, 1) ? PEAK_POS : PEAK_NEG);
      1, 2, 3: raw = $urandom;
      default: raw = $urandom_range(0, 131071) - 65536;
    endcase
    return raw[SW-1:0];
  endfunction

  function automatic logic [MixW-1:0] random_mix();
    case ($urandom_range(0, 19))
      0:       return MixW'($urandom_range(0, BYPASS_MIX));
      1:       return MixW'($urandom_range(MIX_ONE + 1, MIX_ALL_ONES));
      2:       return MIX_ONE;
      default: return MixW'($urandom_range(BYPASS_MIX + 1, MIX_ONE));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------
  // Offer one input beat and record its prediction once taken
  task automatic send_pair(logic [SW-1:0] l, logic [SW-1:0] r, logic [MixW-1:0] m);
    int unsigned gap;
    gap = sender_idle_on ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    left_in_i    <= l;
    right_in_i   <= r;
    mix_amount_i <= m;
    do @(posedge clk_i); while (!in_ready_o);
    pending_pairs.push_back(flanger_predict(l, r, m));
  endtask

  task automatic release_input();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_pairs.size() != 0) @(posedge clk_i);
  endtask

  // Register write; only issued with the unit idle
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_PHASE_INC: cfg_phase_step = data;
      CFG_MAX_DELAY: cfg_peak_delay = data[MaxDlyW-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random stalls, plus the long hold-off when asked
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned pause;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      pause = receiver_idle_on ? $urandom_range(0, 8) : 0;
      if (hold_request) begin
        pause        = pause + HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (pause != 0) begin
        out_ready_i <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin : result_check
    stereo_pair_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pairs.size() == 0) begin
        if (error_count < 10)
          $display("unexpected result beat: L=%0d R=%0d",
                   $signed(left_out_o), $signed(right_out_o));
        error_count++;
      end else begin
        want = pending_pairs.pop_front();
        if (left_out_o !== want.left || right_out_o !== want.right) begin
          if (error_count < 10)
            $display("mismatch: expected L=%0d R=%0d, got L=%0d R=%0d",
                     want.left, want.right,
                     $signed(left_out_o), $signed(right_out_o));
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no beat on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("stereo_feedback_flanger_unit test failed");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset settings: bypass threshold, mix limits and sample extremes
  task automatic test_reset_defaults();
    send_pair('0, '0, '0);
    send_pair(PEAK_POS, PEAK_NEG, BYPASS_MIX);
    send_pair(PEAK_POS, PEAK_NEG, BYPASS_MIX + 17'd1);
    send_pair(PEAK_NEG, PEAK_POS, MIX_ONE);
    send_pair(PEAK_POS, PEAK_POS, MIX_ONE + 17'd1);
    send_pair(PEAK_NEG, PEAK_NEG, MIX_ALL_ONES);
    send_pair(PEAK_POS, PEAK_NEG, MIX_ONE);
    send_pair(24'sd12345, -24'sd54321, 17'd32768);
    release_input();
    wait_drained();
  endtask

  // Register extremes, clamped delay, writes to unused indexes and a half-turn step
  task automatic test_register_extremes();
    // frozen LFO, zero delay
    write_reg(CFG_PHASE_INC, '0);
    write_reg(CFG_MAX_DELAY, '0);
    send_pair(PEAK_POS, PEAK_NEG, MIX_ONE);
    send_pair(PEAK_POS, PEAK_NEG, MIX_ONE);
    release_input();
    wait_drained();
    // full step, longest legal delay
    write_reg(CFG_PHASE_INC, '1);
    write_reg(CFG_MAX_DELAY, DEPTH - 3);
    send_pair(PEAK_NEG, PEAK_POS, MIX_ALL_ONES);
    send_pair(PEAK_POS, PEAK_POS, MIX_ONE);
    release_input();
    wait_drained();
    // delays past the line limit are clamped
    write_reg(CFG_MAX_DELAY, DEPTH - 2);
    send_pair(random_sample(), random_sample(), MIX_ONE);
    release_input();
    wait_drained();
    write_reg(CFG_MAX_DELAY, '1);
    send_pair(random_sample(), random_sample(), MIX_ONE);
    release_input();
    wait_drained();
    // unused indexes must leave both registers alone
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, $urandom);
    send_pair(PEAK_NEG, PEAK_NEG, MIX_ONE);
    send_pair(random_sample(), random_sample(), random_mix());
    release_input();
    wait_drained();
    // half-turn step: the LFO phase moves half a turn per processed pair
    write_reg(CFG_PHASE_INC, 32'h8000_0000);
    write_reg(CFG_MAX_DELAY, 32'd1);
    send_pair(PEAK_POS, PEAK_NEG, MIX_ONE);
    send_pair(PEAK_NEG, PEAK_POS, MIX_ONE);
    release_input();
    wait_drained();
  endtask

  // Long random runs under a range of LFO rates and depths
  task automatic test_random_sweeps();
    int unsigned ph;
    for (ph = 0; ph < 6; ph++) begin
      sender_idle_on   = (ph != 2);
      receiver_idle_on = (ph != 4);
      case (ph)
        0: begin
          write_reg(CFG_PHASE_INC, $urandom_range(1000, 200000));
          write_reg(CFG_MAX_DELAY, $urandom_range(300, DEPTH - 1));
        end
        1: begin
          write_reg(CFG_PHASE_INC, $urandom);
          write_reg(CFG_MAX_DELAY, $urandom_range(0, DEPTH - 1));
        end
        2: begin
          write_reg(CFG_PHASE_INC, '0);
          write_reg(CFG_MAX_DELAY, $urandom_range(0, 40));
        end
        3: begin
          write_reg(CFG_PHASE_INC, $urandom_range(1, 1 << 24));
          write_reg(CFG_MAX_DELAY, DEPTH - 3);
        end
        4: begin
          write_reg(CFG_PHASE_INC, PHASE_INC_RST);
          write_reg(CFG_MAX_DELAY, CfgDataW'(MAX_DELAY_RST));
        end
        default: begin
          write_reg(CFG_PHASE_INC, $urandom);
          write_reg(CFG_MAX_DELAY, $urandom_range(DEPTH - 8, DEPTH - 1));
        end
      endcase
      repeat (SWEEP_ITEMS) send_pair(random_sample(), random_sample(), random_mix());
      release_input();
      wait_drained();
    end
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
  endtask

  // Receiver holds off while the sender keeps offering beats
  task automatic test_output_backpressure();
    sender_idle_on = 1'b0;
    hold_request   = 1'b1;
    repeat (60) send_pair(random_sample(), random_sample(), random_mix());
    release_input();
    wait_drained();
    sender_idle_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      echo_left[i]  = 0;
      echo_right[i] = 0;
    end
    line_ptr       = 0;
    sweep_phase    = '0;
    cfg_phase_step = PHASE_INC_RST;
    cfg_peak_delay = MAX_DELAY_RST;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_random_sweeps();
    test_output_backpressure();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_pairs.size() != 0) begin
      $display("%0d results never arrived", pending_pairs.size());
      error_count++;
    end
    if (error_count == 0)
      $display("stereo_feedback_flanger_unit test passed");
    else
      $display("stereo_feedback_flanger_unit test failed");
    $finish;
  end

endmodule

`default_nettype wire
